/* hdl/tile_ram_to_pattern_map_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the tile RAM to pattern map block
// ----------------------------------------------------------------------------
`ifndef TILE_RAM_TO_PATTERN_MAP_TOP_MACROS_SVH
`define TILE_RAM_TO_PATTERN_MAP_TOP_MACROS_SVH

// Same-cycle implication, quiet while reset is high
`define TPRM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet while reset is high
`define TPRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/tprm_pkg.sv */
// ----------------------------------------------------------------------------
// tprm_pkg
// Widths, constants and word builders for the tile RAM to pattern map block.
// ----------------------------------------------------------------------------
package tprm_pkg;

   localparam int ADDR_W   = 12;
   localparam int DATA_W   = 8;
   localparam int INDEX_W  = 12;
   localparam int WORD_W   = 16;
   localparam int CELL_W   = 10;
   localparam int MEM_DEPTH = 2048;            // {layer, cell}
   localparam int MEM_AW   = $clog2(MEM_DEPTH);

   // Address bit positions
   localparam int TILE_SEL_BIT  = 10;          // 0 colour RAM, 1 tile RAM
   localparam int LAYER_SEL_BIT = 11;          // 0 foreground, 1 background

   localparam logic [WORD_W-1:0] FG_TILE_BASE = 16'h0800;
   localparam logic [WORD_W-1:0] BG_PAL_BASE  = 16'h0008;

   // First word of the cell's pair: ((row * 64) + column) * 2
   function automatic logic [INDEX_W-1:0] pair_base(input logic [CELL_W-1:0] cell_idx);
      pair_base = {cell_idx[9:5], 1'b0, cell_idx[4:0], 1'b0};
   endfunction

   function automatic logic [WORD_W-1:0] fg_pal_word(input logic [DATA_W-1:0] c);
      fg_pal_word = {13'd0, c[6:4]};
   endfunction

   // Horizontal flip lands in bit 14; vertical flip is dropped
   function automatic logic [WORD_W-1:0] bg_pal_word(input logic [DATA_W-1:0] c);
      bg_pal_word = BG_PAL_BASE | {1'b0, c[7], 11'd0, c[6:4]};
   endfunction

   function automatic logic [WORD_W-1:0] fg_tile_word(input logic [DATA_W-1:0] c,
                                                      input logic [DATA_W-1:0] t);
      fg_tile_word = FG_TILE_BASE | {5'd0, c[2:0], t};
   endfunction

   function automatic logic [WORD_W-1:0] bg_tile_word(input logic [DATA_W-1:0] c,
                                                      input logic [DATA_W-1:0] t);
      bg_tile_word = {5'd0, c[2:0], t};
   endfunction

endpackage

/* hdl/tprm_if.sv */
// ----------------------------------------------------------------------------
// tprm_req_if / tprm_rsp_if
// Valid/ready channels for CPU write requests and pattern map word updates.
// ----------------------------------------------------------------------------
interface tprm_req_if import tprm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] data;

   modport source (output valid, output address, output data, input ready);
   modport sink   (input valid, input address, input data, output ready);
endinterface

interface tprm_rsp_if import tprm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               layer;
   logic [INDEX_W-1:0] word_index;
   logic [WORD_W-1:0]  word_value;
   logic               last;

   modport source (output valid, output layer, output word_index, output word_value,
                   output last, input ready);
   modport sink   (input valid, input layer, input word_index, input word_value,
                   input last, output ready);
endinterface

/* hdl/tprm_ram.sv */
// ----------------------------------------------------------------------------
// tprm_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tprm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/tile_ram_to_pattern_map_top.sv */
// Sequence: a request is accepted in IDLE, compared in LOOKUP, and the first word is
// registered on the response port in SEND.
// Requests: a colour write emits two words, a tile write one, an unchanged byte none;
// a new request is taken only in IDLE, after the last word of the previous one is accepted.
// Reset: synchronous; the RAMs are then zeroed by a clearing pass over all 2048
// entries, during which no request is accepted.
// ----------------------------------------------------------------------------
// tile_ram_to_pattern_map_top
// Stores CPU tile RAM writes and emits pattern map word updates on change.
// ----------------------------------------------------------------------------
module tile_ram_to_pattern_map_top import tprm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tprm_req_if.sink   req_chan,
   tprm_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_SEND} state_type;

   localparam logic [MEM_AW-1:0] CLEAR_LAST = MEM_AW'(MEM_DEPTH - 1);

   state_type          state_ff;
   logic [MEM_AW-1:0]  clear_ff;
   logic [MEM_AW-1:0]  entry_ff;
   logic               is_tile_ff;
   logic [DATA_W-1:0]  data_ff;
   logic               rsp_valid_ff;
   logic               layer_ff;
   logic [INDEX_W-1:0] index_ff;
   logic [WORD_W-1:0]  value_ff;
   logic               last_ff;
   logic               second_ff;
   logic [WORD_W-1:0]  second_value_ff;

   logic [MEM_AW-1:0]  rd_addr;
   logic [MEM_AW-1:0]  wr_addr;
   logic [DATA_W-1:0]  wr_data;
   logic               colour_we;
   logic               tile_we;
   logic [DATA_W-1:0]  colour_rd;
   logic [DATA_W-1:0]  tile_rd;
   logic [DATA_W-1:0]  stored;
   logic               changed;
   logic [DATA_W-1:0]  colour_val;
   logic [DATA_W-1:0]  tile_val;
   logic               entry_layer;
   logic [INDEX_W-1:0] base;
   logic [WORD_W-1:0]  pal_word;
   logic [WORD_W-1:0]  tile_word;

   // Both RAMs are read at the same {layer, cell}; the target byte is compared,
   // the partner byte feeds the tile-number word.
   assign rd_addr = {req_chan.address[LAYER_SEL_BIT], req_chan.address[CELL_W-1:0]};

   assign stored     = is_tile_ff ? tile_rd : colour_rd;
   assign changed    = (stored != data_ff);
   assign colour_val = is_tile_ff ? colour_rd : data_ff;
   assign tile_val   = is_tile_ff ? data_ff : tile_rd;

   assign entry_layer = entry_ff[MEM_AW-1];
   assign base        = pair_base(entry_ff[CELL_W-1:0]);
   assign pal_word    = entry_layer ? bg_pal_word(data_ff) : fg_pal_word(data_ff);
   assign tile_word   = entry_layer ? bg_tile_word(colour_val, tile_val)
                                    : fg_tile_word(colour_val, tile_val);

   // Write back in the lookup cycle; the next request is read no earlier than
   // the following edge, so no forwarding is needed.
   always_comb begin
      wr_addr   = entry_ff;
      wr_data   = data_ff;
      colour_we = 1'b0;
      tile_we   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_addr   = clear_ff;
            wr_data   = '0;
            colour_we = 1'b1;
            tile_we   = 1'b1;
         end
         ST_LOOKUP: begin
            colour_we = changed && !is_tile_ff;
            tile_we   = changed && is_tile_ff;
         end
         default: begin
         end
      endcase
   end

   tprm_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_colour_ram (
      .clock   (clock),
      .wr_en   (colour_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (colour_rd)
   );

   tprm_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_tile_ram (
      .clock   (clock),
      .wr_en   (tile_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (tile_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               clear_ff <= clear_ff + 1'b1;
               if (clear_ff == CLEAR_LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_chan.valid) begin
                  entry_ff   <= rd_addr;
                  is_tile_ff <= req_chan.address[TILE_SEL_BIT];
                  data_ff    <= req_chan.data;
                  state_ff   <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               if (changed) begin
                  rsp_valid_ff    <= 1'b1;
                  layer_ff        <= entry_layer;
                  second_value_ff <= tile_word;
                  if (is_tile_ff) begin
                     index_ff  <= {base[INDEX_W-1:1], 1'b1};
                     value_ff  <= tile_word;
                     last_ff   <= 1'b1;
                     second_ff <= 1'b0;
                  end else begin
                     index_ff  <= base;
                     value_ff  <= pal_word;
                     last_ff   <= 1'b0;
                     second_ff <= 1'b1;
                  end
                  state_ff <= ST_SEND;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_SEND: begin
               if (rsp_chan.ready) begin
                  if (second_ff) begin
                     // advance to the tile-number word of the pair
                     index_ff  <= {index_ff[INDEX_W-1:1], 1'b1};
                     value_ff  <= second_value_ff;
                     last_ff   <= 1'b1;
                     second_ff <= 1'b0;
                  end else begin
                     rsp_valid_ff <= 1'b0;
                     state_ff     <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.layer      = layer_ff;
   assign rsp_chan.word_index = index_ff;
   assign rsp_chan.word_value = value_ff;
   assign rsp_chan.last       = last_ff;

endmodule

/* hdl/tprm_checker.sv */
// ----------------------------------------------------------------------------
// tprm_checker
// Port-level checks on request and response ordering of the top level.
// ----------------------------------------------------------------------------
`include "tile_ram_to_pattern_map_top_macros.svh"

module tprm_checker import tprm_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_layer,
   input logic [INDEX_W-1:0] rsp_word_index,
   input logic [WORD_W-1:0]  rsp_word_value,
   input logic               rsp_last
);

   logic rsp_stall;
   logic rsp_take_first;

   assign rsp_stall      = rsp_valid && !rsp_ready;
   assign rsp_take_first = rsp_valid && rsp_ready && !rsp_last;

   // hold a stalled response
   `TPRM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word_index) && $stable(rsp_word_value) && $stable(rsp_last), "stalled response changed")

   // the tile word follows the palette word at the odd index of the same pair
   `TPRM_ASSERT_NEXT(a_pair_follow, clock, reset, rsp_take_first, rsp_valid && rsp_last && rsp_word_index[0] && rsp_word_index[INDEX_W-1:1] == $past(rsp_word_index[INDEX_W-1:1]) && rsp_layer == $past(rsp_layer), "second word of pair missing")

   `TPRM_ASSERT_NOW(a_first_even, clock, reset, rsp_valid && !rsp_last, !rsp_word_index[0], "palette word at odd index")

   `TPRM_ASSERT_NOW(a_no_overlap, clock, reset, rsp_valid, !req_ready, "request taken while response pending")

   `TPRM_ASSERT_NEXT(a_lookup_gap, clock, reset, req_valid && req_ready, !rsp_valid && !req_ready, "no lookup cycle after request")

endmodule

bind tile_ram_to_pattern_map_top tprm_checker u_tprm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_layer      (rsp_chan.layer),
   .rsp_word_index (rsp_chan.word_index),
   .rsp_word_value (rsp_chan.word_value),
   .rsp_last       (rsp_chan.last)
);

/* verif/tb_tile_ram_to_pattern_map_top.sv */
// ----------------------------------------------------------------------------
// tb_tile_ram_to_pattern_map_top
// Drives CPU tile RAM writes into the block and checks every pattern map word
// it emits against a local model of the four tile RAMs, under bursty requests,
// a stalling receiver and long receiver hold-offs that back up the pipeline.
// ----------------------------------------------------------------------------
module tb_tile_ram_to_pattern_map_top;
   import tprm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WRITES = 1700;
   localparam int IDLE_LIMIT    = 20000;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AT_FIRST = 150;
   localparam int HOLD_AT_LAST  = 1000;
   localparam int DRAIN_CYCLES  = 16;

   typedef enum logic [1:0] {
      RAM_FG_COLOUR = 2'd0,
      RAM_FG_TILE   = 2'd1,
      RAM_BG_COLOUR = 2'd2,
      RAM_BG_TILE   = 2'd3
   } ram_sel_e;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_COIN,
      RX_ONE_IN_FOUR,
      RX_MOSTLY
   } rx_pattern_e;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] data;
   } cpu_write_t;

   typedef struct packed {
      logic               layer;
      logic [INDEX_W-1:0] word_index;
      logic [WORD_W-1:0]  word_value;
      logic               last;
   } map_word_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tprm_req_if req_if ();
   tprm_rsp_if rsp_if ();

   tile_ram_to_pattern_map_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   cpu_write_t  cpu_writes[$];
   map_word_t   pending_map_words[$];
   logic [DATA_W-1:0] tile_rams [4][1024];

   logic        req_fire = 1'b0;
   int          error_count = 0;
   int          writes_accepted = 0;
   int          colour_writes = 0;
   int          tile_writes = 0;
   int          unchanged_writes = 0;
   int          words_checked = 0;
   int          idle_cycles = 0;

   int          burst_left = 1;
   int          gap_left = 0;
   int          hold_left = 0;
   int          holds_done = 0;
   int          mode_left = 0;
   int          rx_phase = 0;
   rx_pattern_e rx_mode = RX_ALWAYS;

   task automatic push_write(input ram_sel_e sel, input logic [CELL_W-1:0] cell_idx,
                             input logic [DATA_W-1:0] d);
      cpu_writes.push_back('{address: {sel, cell_idx}, data: d});
   endtask

   // Store the byte and queue the map words it changes
   task automatic translate_write(input logic [ADDR_W-1:0] addr,
                                  input logic [DATA_W-1:0] d);
      ram_sel_e           sel;
      logic [CELL_W-1:0]  cell_idx;
      logic [INDEX_W-1:0] base;
      logic               bg;
      logic [DATA_W-1:0]  colour;
      logic [DATA_W-1:0]  tile;
      logic [WORD_W-1:0]  pal;
      logic [WORD_W-1:0]  tword;
      int                 row;
      int                 col;
      sel      = ram_sel_e'(addr[11:10]);
      cell_idx = addr[CELL_W-1:0];
      row      = cell_idx[9:5];
      col      = cell_idx[4:0];
      base     = INDEX_W'((row * 64 + col) * 2);
      if (tile_rams[sel][cell_idx] == d) begin
         unchanged_writes++;
         return;
      end
      tile_rams[sel][cell_idx] = d;
      bg     = (sel == RAM_BG_COLOUR) || (sel == RAM_BG_TILE);
      colour = tile_rams[bg ? RAM_BG_COLOUR : RAM_FG_COLOUR][cell_idx];
      tile   = tile_rams[bg ? RAM_BG_TILE : RAM_FG_TILE][cell_idx];
      // Vertical flip (colour bit 3) has no place in the word
      if (bg) begin
         pal   = 16'h0008 | ((colour & 8'h70) >> 4) | (WORD_W'(colour & 8'h80) << 7);
         tword = (WORD_W'(colour & 8'h07) << 8) | tile;
      end else begin
         pal   = (colour & 8'h70) >> 4;
         tword = 16'h0800 | (WORD_W'(colour & 8'h07) << 8) | tile;
      end
      if ((sel == RAM_FG_COLOUR) || (sel == RAM_BG_COLOUR)) begin
         colour_writes++;
         pending_map_words.push_back('{bg, base, pal, 1'b0});
      end else begin
         tile_writes++;
      end
      pending_map_words.push_back('{bg, base + INDEX_W'(1), tword, 1'b1});
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         error_count++;
      end
   endtask

   // Sample both channels on the rising edge
   always @(posedge clock) begin
      map_word_t want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            writes_accepted++;
            translate_write(req_if.address, req_if.data);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_map_words.size() == 0) begin
               $error("map word with none expected: layer %0d index 0x%0h value 0x%0h",
                      rsp_if.layer, rsp_if.word_index, rsp_if.word_value);
               error_count++;
            end else begin
               want = pending_map_words.pop_front();
               check_field("layer", want.layer, rsp_if.layer);
               check_field("word_index", want.word_index, rsp_if.word_index);
               check_field("word_value", want.word_value, rsp_if.word_value);
               check_field("last", want.last, rsp_if.last);
               words_checked++;
            end
         end
      end
   end

   // Request driver: bursts of writes separated by random gaps
   always @(negedge clock) begin
      cpu_write_t nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (cpu_writes.size() != 0) begin
            nxt = cpu_writes.pop_front();
            req_if.valid   <= 1'b1;
            req_if.address <= nxt.address;
            req_if.data    <= nxt.data;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 48);
               gap_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 6);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver: changing stall patterns plus two long hold-offs
   always @(negedge clock) begin
      logic rdy;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (hold_left == 0 && holds_done < 2 &&
             writes_accepted >= ((holds_done == 0) ? HOLD_AT_FIRST : HOLD_AT_LAST)) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         if (mode_left == 0) begin
            rx_mode   = rx_pattern_e'($urandom_range(0, 3));
            mode_left = $urandom_range(32, 256);
         end
         mode_left--;
         rx_phase++;
         case (rx_mode)
            RX_ALWAYS:      rdy = 1'b1;
            RX_COIN:        rdy = 1'($urandom_range(0, 1));
            RX_ONE_IN_FOUR: rdy = (rx_phase % 4 == 0);
            default:        rdy = ($urandom_range(0, 9) != 0);
         endcase
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end
         rsp_if.ready <= rdy;
      end
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $error("timeout: no request or map word accepted for %0d cycles", IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      cpu_write_t                recent [8];
      cpu_write_t                w;
      logic [CELL_W-1:0]         hot_cells [8];
      int                        pick;

      req_if.valid   = 1'b0;
      req_if.address = '0;
      req_if.data    = '0;
      rsp_if.ready   = 1'b0;
      foreach (tile_rams[s, c]) tile_rams[s][c] = '0;
      foreach (recent[i]) recent[i] = '0;
      hot_cells = '{10'h000, 10'h001, 10'h01F, 10'h020,
                    10'h3E0, 10'h3FF, 10'h155, 10'h2AA};

      // Directed: corners, unchanged bytes, flip bits, both layers
      push_write(RAM_FG_COLOUR, 10'h000, 8'hFF);
      push_write(RAM_FG_COLOUR, 10'h000, 8'hFF);
      push_write(RAM_BG_TILE,   10'h155, 8'h00);
      push_write(RAM_FG_TILE,   10'h000, 8'hA5);
      push_write(RAM_FG_TILE,   10'h3FF, 8'h01);
      push_write(RAM_FG_COLOUR, 10'h3FF, 8'h77);
      push_write(RAM_BG_COLOUR, 10'h3FF, 8'h80);
      push_write(RAM_BG_COLOUR, 10'h3FF, 8'h08);
      push_write(RAM_BG_TILE,   10'h3FF, 8'hFF);
      push_write(RAM_BG_TILE,   10'h021, 8'h5A);
      push_write(RAM_BG_COLOUR, 10'h021, 8'h7F);
      push_write(RAM_FG_COLOUR, 10'h3E0, 8'h70);
      push_write(RAM_FG_COLOUR, 10'h01F, 8'h07);
      push_write(RAM_FG_COLOUR, 10'h000, 8'h00);
      push_write(RAM_BG_TILE,   10'h3FF, 8'h00);
      push_write(RAM_BG_COLOUR, 10'h2AA, 8'hFF);
      push_write(RAM_FG_TILE,   10'h2AA, 8'hFF);

      // Random: hot cells to pair colour and tile writes, repeats for unchanged bytes
      for (int n = 0; n < RANDOM_WRITES; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            w = recent[$urandom_range(0, 7)];
         end else begin
            w.address[11:10] = 2'($urandom_range(0, 3));
            if (pick < 60)
               w.address[CELL_W-1:0] = hot_cells[$urandom_range(0, 7)];
            else
               w.address[CELL_W-1:0] = CELL_W'($urandom_range(0, 1023));
            if ($urandom_range(0, 3) == 0)
               w.data = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
               w.data = DATA_W'($urandom_range(0, 255));
         end
         recent[n % 8] = w;
         cpu_writes.push_back(w);
      end

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      while (cpu_writes.size() != 0 || req_if.valid) @(posedge clock);
      while (pending_map_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d writes: %0d colour, %0d tile, %0d unchanged bytes",
               writes_accepted, colour_writes, tile_writes, unchanged_writes);
      $display("Checked %0d map words across %0d receiver hold-offs",
               words_checked, holds_done);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/tprm_pkg.sv
hdl/tprm_if.sv
hdl/tprm_ram.sv
hdl/tile_ram_to_pattern_map_top.sv
hdl/tprm_checker.sv
verif/tb_tile_ram_to_pattern_map_top.sv
